// ===== rtl/ngse_pkg.sv =====
// Shared types, constants and the control program of the nearest greater/smaller element engine.
package ngse_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 64;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned ANSWER_W         = VALUE_W + 1;
  localparam int unsigned CFG_INDEX_W      = 1;
  localparam int unsigned CFG_DATA_W       = 1;
  localparam int unsigned STEP_W           = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_DIRECTION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_KIND     = 1'd1;

  // Jump conditions of the control program.
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_FINAL = 3'd2,
    COND_POP      = 3'd3,
    COND_MORE     = 3'd4,
    COND_OUT_BUSY = 3'd5,
    COND_MORE_OUT = 3'd6
  } cond_e;

  // Program step addresses. The refill step after a pop sits out of line, so
  // that a compare without a pop falls through to the loop test.
  localparam logic [STEP_W-1:0] PC_LOAD    = 4'd0;
  localparam logic [STEP_W-1:0] PC_INIT    = 4'd1;
  localparam logic [STEP_W-1:0] PC_FETCH   = 4'd2;
  localparam logic [STEP_W-1:0] PC_LATCH   = 4'd3;
  localparam logic [STEP_W-1:0] PC_CMP     = 4'd4;
  localparam logic [STEP_W-1:0] PC_NEXT    = 4'd5;
  localparam logic [STEP_W-1:0] PC_EMIT_RD = 4'd6;
  localparam logic [STEP_W-1:0] PC_EMIT_LD = 4'd7;
  localparam logic [STEP_W-1:0] PC_DONE    = 4'd8;
  localparam logic [STEP_W-1:0] PC_REFILL  = 4'd9;

  // One control word: datapath strobes, a jump condition and its target.
  typedef struct packed {
    logic              load;
    logic              init;
    logic              fetch;
    logic              latch;
    logic              cmp;
    logic              refill;
    logic              emit_rd;
    logic              emit_ld;
    logic              done;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Datapath status seen by the jump logic.
  typedef struct packed {
    logic final_acc;
    logic pop;
    logic more;
    logic out_busy;
    logic more_out;
  } status_t;

  localparam ctl_t CTL_IDLE = '{
    load: 1'b0, init: 1'b0, fetch: 1'b0, latch: 1'b0, cmp: 1'b0, refill: 1'b0,
    emit_rd: 1'b0, emit_ld: 1'b0, done: 1'b0, cond: COND_ALWAYS, target: PC_LOAD
  };

  // The control program: without a taken jump the step counter moves on by one.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] pc);
    ctl_t w;
    w = CTL_IDLE;
    case (pc)
      PC_LOAD: begin
        w.load = 1'b1; w.cond = COND_NO_FINAL; w.target = PC_LOAD;
      end
      PC_INIT: begin
        w.init = 1'b1; w.cond = COND_NEVER;
      end
      PC_FETCH: begin
        w.fetch = 1'b1; w.cond = COND_NEVER;
      end
      PC_LATCH: begin
        w.latch = 1'b1; w.cond = COND_NEVER;
      end
      PC_CMP: begin
        w.cmp = 1'b1; w.cond = COND_POP; w.target = PC_REFILL;
      end
      PC_REFILL: begin
        w.refill = 1'b1; w.cond = COND_ALWAYS; w.target = PC_CMP;
      end
      PC_NEXT: begin
        w.cond = COND_MORE; w.target = PC_FETCH;
      end
      PC_EMIT_RD: begin
        w.emit_rd = 1'b1; w.cond = COND_OUT_BUSY; w.target = PC_EMIT_RD;
      end
      PC_EMIT_LD: begin
        w.emit_ld = 1'b1; w.cond = COND_MORE_OUT; w.target = PC_EMIT_RD;
      end
      PC_DONE: begin
        w.done = 1'b1; w.cond = COND_ALWAYS; w.target = PC_LOAD;
      end
      default: begin
        w = CTL_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ngse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ngse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ngse_seq.sv =====
// Step counter, control program lookup and conditional jump logic.
module ngse_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ngse_pkg::status_t status_i,
  output ngse_pkg::ctl_t   ctl_o
);

  logic [ngse_pkg::STEP_W-1:0] pc_q, pc_d;
  ngse_pkg::ctl_t              ctl;
  logic                        take;

  assign ctl = ngse_pkg::ucode(pc_q);

  always_comb begin
    case (ctl.cond)
      ngse_pkg::COND_NEVER:    take = 1'b0;
      ngse_pkg::COND_ALWAYS:   take = 1'b1;
      ngse_pkg::COND_NO_FINAL: take = !status_i.final_acc;
      ngse_pkg::COND_POP:      take = status_i.pop;
      ngse_pkg::COND_MORE:     take = status_i.more;
      ngse_pkg::COND_OUT_BUSY: take = status_i.out_busy;
      ngse_pkg::COND_MORE_OUT: take = status_i.more_out;
      default:                 take = 1'b1;
    endcase
    pc_d = take ? ctl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ngse_pkg::PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

// ===== rtl/ngse_dp.sv =====
// Datapath: element, stack and answer memories, counters, compare and output register.
module ngse_dp #(
  parameter int unsigned MAX_ELEMENTS = ngse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ngse_pkg::ctl_t                       ctl_i,
  output ngse_pkg::status_t                    status_o,
  input  logic                                 cfg_we_i,
  input  logic [ngse_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [ngse_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ngse_pkg::VALUE_W-1:0]  item_value_i,
  input  logic                                 final_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ngse_pkg::VALUE_W-1:0]  match_value_o,
  output logic                                 match_found_o,
  output logic                                 overflow_seen_o,
  output logic                                 final_result_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned VW = ngse_pkg::VALUE_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  logic          dir_q, kind_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] step_q, step_d;
  logic [CW-1:0] oidx_q, oidx_d;
  logic [AW-1:0] idx_q, idx_d;
  logic signed [VW-1:0] cur_q, cur_d;
  logic signed [VW-1:0] top_q, top_d;

  logic          out_valid_q, out_valid_d;
  logic signed [VW-1:0] out_value_q;
  logic          out_found_q, out_ovf_q, out_final_q;

  logic          in_acc, out_free, blocks, pop, push;
  logic [CW-1:0] last_cnt;
  logic [AW-1:0] solve_addr;

  logic [VW-1:0]               elem_rdata, stack_rdata;
  logic [ngse_pkg::ANSWER_W-1:0] ans_rdata, ans_wdata;

  assign in_stall_o = !ctl_i.load;
  assign in_acc     = in_valid_i && ctl_i.load;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_cnt   = cnt_q - 1'b1;

  // The stacked value blocks the current one unless it is strictly greater (or smaller).
  assign blocks = kind_q ? (top_q >= cur_q) : (top_q <= cur_q);
  assign pop    = (sp_q != '0) && blocks;
  assign push   = ctl_i.cmp && !pop && (sp_q < MAX_CNT);

  assign solve_addr = dir_q ? AW'(last_cnt - step_q) : AW'(step_q);

  assign status_o.final_acc = in_acc && final_item_i;
  assign status_o.pop       = pop;
  assign status_o.more      = step_q != cnt_q;
  assign status_o.out_busy  = !out_free;
  assign status_o.more_out  = oidx_q != last_cnt;

  assign ans_wdata = (sp_q != '0) ? {1'b1, top_q} : '0;

  ngse_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (cnt_q < MAX_CNT)),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (item_value_i),
    .re_i    (ctl_i.fetch),
    .raddr_i (solve_addr),
    .rdata_o (elem_rdata)
  );

  ngse_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (AW'(sp_q)),
    .wdata_i (cur_q),
    .re_i    (ctl_i.cmp && pop),
    .raddr_i (AW'(sp_q - CW'(2))),
    .rdata_o (stack_rdata)
  );

  ngse_ram #(.WIDTH(ngse_pkg::ANSWER_W), .DEPTH(MAX_ELEMENTS)) u_ans_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.cmp && !pop),
    .waddr_i (idx_q),
    .wdata_i (ans_wdata),
    .re_i    (ctl_i.emit_rd),
    .raddr_i (AW'(oidx_q)),
    .rdata_o (ans_rdata)
  );

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    step_d      = step_q;
    oidx_d      = oidx_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    top_d       = top_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_acc) begin
      if (cnt_q < MAX_CNT) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (ctl_i.init) begin
      sp_d   = '0;
      step_d = '0;
      oidx_d = '0;
    end
    if (ctl_i.fetch) begin
      idx_d = solve_addr;
    end
    if (ctl_i.latch) begin
      cur_d = elem_rdata;
    end
    if (ctl_i.cmp) begin
      if (pop) begin
        sp_d = sp_q - 1'b1;
      end else begin
        step_d = step_q + 1'b1;
        if (push) begin
          sp_d  = sp_q + 1'b1;
          top_d = cur_q;
        end
      end
    end
    if (ctl_i.refill) begin
      top_d = stack_rdata;
    end
    if (ctl_i.emit_ld) begin
      out_valid_d = 1'b1;
      oidx_d      = oidx_q + 1'b1;
    end
    if (ctl_i.done) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      sp_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      kind_q      <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      step_q      <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ngse_pkg::REG_SEARCH_DIRECTION: dir_q  <= cfg_data_i[0];
          ngse_pkg::REG_COMPARE_KIND:     kind_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      step_q      <= step_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    top_q <= top_d;
    if (ctl_i.emit_ld) begin
      out_value_q <= ans_rdata[VW-1:0];
      out_found_q <= ans_rdata[VW];
      out_ovf_q   <= ovf_q;
      out_final_q <= oidx_q == last_cnt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_value_o   = out_value_q;
  assign match_found_o   = out_found_q;
  assign overflow_seen_o = out_ovf_q;
  assign final_result_o  = out_final_q;

endmodule

// ===== rtl/nearest_greater_smaller_element.sv =====
// Top level of the nearest greater/smaller element engine.
//
//   Channel  Direction  Handshake                 Payload
//   ------   ---------  ------------------------  ------------------------------------------
//   in       input      in_valid_i / in_stall_o   item_value_i, final_item_i
//   out      output     out_valid_o / out_stall_i match_value_o, match_found_o,
//                                                 overflow_seen_o, final_result_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// Items are loaded at one per cycle while the block is collecting a sequence.
// After the final item the sequencer runs a monotonic-stack pass: each element
// is fetched, latched, compared and followed by the loop test, and every stack
// pop adds a refill step and another compare; the answer memory is then read
// out one result at a time, each read followed by a load of the result register.
// Reset is asynchronous and active low; it clears all control state, while the
// memories hold nothing meaningful until the current run writes them.
// A stall on the output holds the result register and the read-out loop; new
// input is refused (in_stall_o high) from the final item until the last
// result of the run has been loaded into the result register.
module nearest_greater_smaller_element #(
  parameter int unsigned MAX_ELEMENTS = ngse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration writes.
  input  logic                                 cfg_we_i,
  input  logic [ngse_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [ngse_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input sequence.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ngse_pkg::VALUE_W-1:0]  item_value_i,
  input  logic                                 final_item_i,
  // Results.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ngse_pkg::VALUE_W-1:0]  match_value_o,
  output logic                                 match_found_o,
  output logic                                 overflow_seen_o,
  output logic                                 final_result_o
);

  // The control word of the current step, and the status bits that steer its jump.
  ngse_pkg::ctl_t    ctl;
  ngse_pkg::status_t status;

  // The sequencer walks the program: load, solve loop with pops, read-out loop.
  ngse_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  // The datapath holds the three memories, the stack pointer and the result register.
  ngse_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .item_value_i    (item_value_i),
    .final_item_i    (final_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .match_value_o   (match_value_o),
    .match_found_o   (match_found_o),
    .overflow_seen_o (overflow_seen_o),
    .final_result_o  (final_result_o)
  );

endmodule
